FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the RTL file frustum_sphere_classifier.sv
// Clocked property checks with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of aclk outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check a property on every rising edge of aclk, reset included
`define ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

FILE: sv/fsc_pkg.sv
// ----------------------------------------------------------------------------
// fsc_pkg
// Widths, register indexes, reset values and verdict codes of the frustum
// sphere classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package fsc_pkg;

    // Field widths
    localparam int COORD_W  = 21;               // Q13.8 coordinate
    localparam int OFS_W    = COORD_W + 1;      // centre minus camera position
    localparam int AXIS_W   = 21;               // Q2.19 axis component
    localparam int PROD_W   = OFS_W + AXIS_W;   // one offset-by-axis product
    localparam int SUM_W    = PROD_W + 2;       // sum of three products
    localparam int AXIS_SH  = 19;               // Q.27 to Q.8
    localparam int AXC_W    = SUM_W - AXIS_SH;  // floored axis coordinate
    localparam int DEPTH_W  = AXC_W + 1;        // negated back coordinate
    localparam int TAN_W    = 24;               // Q8.16 tangents and factor
    localparam int RAD_W    = 20;               // Q12.8 unsigned radius
    localparam int FRAC_SH  = 16;               // Q8.16 scaling shift
    localparam int ZPROD_W  = DEPTH_W + TAN_W + 1;
    localparam int ZZ_W     = ZPROD_W - 1 - FRAC_SH;
    localparam int DPROD_W  = TAN_W + RAD_W;
    localparam int DIST_W   = DPROD_W - FRAC_SH;
    localparam int CMP_W    = ZZ_W + 2;         // bound sums and compares

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;
    localparam int VEC_W      = 3 * COORD_W;
    localparam int NF_W       = 2 * COORD_W;

    localparam logic [CFG_IDX_W-1:0] REG_CAM_POSITION   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_RIGHT_AXIS = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_UP_AXIS    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_BACK_AXIS  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_FAR       = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TAN_VERTICAL   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TAN_HORIZONTAL = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPHERE_FACTOR  = 4'd7;

    // Register defaults: unit axes, near 1.0, far 1000.0, factor about sqrt(2)
    localparam logic [VEC_W-1:0] RST_CAM_POSITION   = 63'd0;
    localparam logic [VEC_W-1:0] RST_CAM_RIGHT_AXIS = 63'd524288;
    localparam logic [VEC_W-1:0] RST_CAM_UP_AXIS    = 63'd1099511627776;
    localparam logic [VEC_W-1:0] RST_CAM_BACK_AXIS  = 63'd2305843009213693952;
    localparam logic [NF_W-1:0]  RST_NEAR_FAR       = 42'd536870912256;
    localparam logic [TAN_W-1:0] RST_TAN_VERTICAL   = 24'd65536;
    localparam logic [TAN_W-1:0] RST_TAN_HORIZONTAL = 24'd65536;
    localparam logic [TAN_W-1:0] RST_SPHERE_FACTOR  = 24'd92682;

    // Pipeline depth
    localparam int NSTAGE = 6;

    typedef enum logic [1:0] {
        VERDICT_INSIDE    = 2'd0,
        VERDICT_INTERSECT = 2'd1,
        VERDICT_OUTSIDE   = 2'd2
    } verdict_t;

    // Pick one signed 21-bit lane out of a packed three-lane vector
    function automatic logic signed [COORD_W-1:0] lane(input logic [VEC_W-1:0] packed_vec,
                                                       input int k);
        lane = $signed(packed_vec[COORD_W*k +: COORD_W]);
    endfunction

endpackage

`default_nettype wire

FILE: sv/frustum_sphere_classifier.sv
// ----------------------------------------------------------------------------
// frustum_sphere_classifier
// Radar-method sphere against view frustum test: inside, intersect, outside.
// ----------------------------------------------------------------------------
// Usage: the block takes one sphere per clock unless m_ready holds a full
// pipeline, and passes it through six register stages (offset, nine axis
// products, axis sums, depth-by-tangent products, bound sums, compare and output
// register); each stage moves on its own whenever the stage after it is free,
// so bubbles close up under backpressure. The configuration port is always
// ready and a write takes effect on the next cycle; write it only while no
// sphere is in flight. Indexes beyond sphere_factor are ignored.
`default_nettype none
`include "assert_macros.svh"

module frustum_sphere_classifier (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // configuration write channel
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [fsc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [fsc_pkg::CFG_DATA_W-1:0]       cfg_data,
    // sphere input channel
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [fsc_pkg::COORD_W-1:0]   s_center_x,
    input  wire logic signed [fsc_pkg::COORD_W-1:0]   s_center_y,
    input  wire logic signed [fsc_pkg::COORD_W-1:0]   s_center_z,
    input  wire logic [fsc_pkg::RAD_W-1:0]            s_radius,
    // verdict output channel
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [1:0]                                m_verdict
);
    import fsc_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [VEC_W-1:0] cam_position_reg, cam_right_reg, cam_up_reg, cam_back_reg;
    logic [NF_W-1:0]  near_far_reg;
    logic [TAN_W-1:0] tan_vert_reg, tan_horiz_reg, sphere_factor_reg;

    assign cfg_ready = 1'b1;

    // Write the addressed register, drop unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_position_reg  <= RST_CAM_POSITION;
            cam_right_reg     <= RST_CAM_RIGHT_AXIS;
            cam_up_reg        <= RST_CAM_UP_AXIS;
            cam_back_reg      <= RST_CAM_BACK_AXIS;
            near_far_reg      <= RST_NEAR_FAR;
            tan_vert_reg      <= RST_TAN_VERTICAL;
            tan_horiz_reg     <= RST_TAN_HORIZONTAL;
            sphere_factor_reg <= RST_SPHERE_FACTOR;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_CAM_POSITION:   cam_position_reg  <= cfg_data[VEC_W-1:0];
                REG_CAM_RIGHT_AXIS: cam_right_reg     <= cfg_data[VEC_W-1:0];
                REG_CAM_UP_AXIS:    cam_up_reg        <= cfg_data[VEC_W-1:0];
                REG_CAM_BACK_AXIS:  cam_back_reg      <= cfg_data[VEC_W-1:0];
                REG_NEAR_FAR:       near_far_reg      <= cfg_data[NF_W-1:0];
                REG_TAN_VERTICAL:   tan_vert_reg      <= cfg_data[TAN_W-1:0];
                REG_TAN_HORIZONTAL: tan_horiz_reg     <= cfg_data[TAN_W-1:0];
                REG_SPHERE_FACTOR:  sphere_factor_reg <= cfg_data[TAN_W-1:0];
                default: ;
            endcase
        end
    end

    // Axes in the order back, right, up
    logic [VEC_W-1:0] axis_vec [3];
    assign axis_vec[0] = cam_back_reg;
    assign axis_vec[1] = cam_right_reg;
    assign axis_vec[2] = cam_up_reg;

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    logic [NSTAGE-1:0] vld_reg, vld_next, stage_en;
    logic              in_acc, out_acc;

    // A stage advances when it is empty or the stage after it advances
    always_comb begin
        stage_en[NSTAGE-1] = !vld_reg[NSTAGE-1] || m_ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            stage_en[k] = !vld_reg[k] || stage_en[k+1];
        end
    end

    assign s_ready = stage_en[0];
    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    // Move valid bits along with the data
    always_comb begin
        vld_next[0] = stage_en[0] ? s_valid : vld_reg[0];
        for (int k = 1; k < NSTAGE; k++) begin
            vld_next[k] = stage_en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: offset from camera position
    // ------------------------------------------------------------------
    logic signed [OFS_W-1:0] ofs_reg [3];
    logic signed [OFS_W-1:0] ofs_next [3];
    logic [RAD_W-1:0]        rad1_reg;

    always_comb begin
        ofs_next[0] = OFS_W'(s_center_x) - OFS_W'(lane(cam_position_reg, 0));
        ofs_next[1] = OFS_W'(s_center_y) - OFS_W'(lane(cam_position_reg, 1));
        ofs_next[2] = OFS_W'(s_center_z) - OFS_W'(lane(cam_position_reg, 2));
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            ofs_reg  <= ofs_next;
            rad1_reg <= s_radius;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: nine offset-by-axis products and the radius term product
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] prod_reg [3][3];
    logic signed [PROD_W-1:0] prod_next [3][3];
    logic [DPROD_W-1:0]       dprod_reg, dprod_next;
    logic [RAD_W-1:0]         rad2_reg;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int k = 0; k < 3; k++) begin
                prod_next[a][k] = PROD_W'(ofs_reg[k]) * PROD_W'(lane(axis_vec[a], k));
            end
        end
        dprod_next = DPROD_W'(sphere_factor_reg) * DPROD_W'(rad1_reg);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            prod_reg  <= prod_next;
            dprod_reg <= dprod_next;
            rad2_reg  <= rad1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: axis sums floored to Q.8, depth negated
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0]   sum_c [3];
    logic signed [DEPTH_W-1:0] az3_reg, az3_next;
    logic signed [AXC_W-1:0]   ax3_reg, ay3_reg;
    logic [DIST_W-1:0]         dist3_reg;
    logic [RAD_W-1:0]          rad3_reg;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            sum_c[a] = SUM_W'(prod_reg[a][0]) + SUM_W'(prod_reg[a][1])
                     + SUM_W'(prod_reg[a][2]);
        end
        az3_next = -$signed({sum_c[0][SUM_W-1], sum_c[0][SUM_W-1:AXIS_SH]});
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            az3_reg   <= az3_next;
            ax3_reg   <= $signed(sum_c[1][SUM_W-1:AXIS_SH]);
            ay3_reg   <= $signed(sum_c[2][SUM_W-1:AXIS_SH]);
            dist3_reg <= dprod_reg[DPROD_W-1:FRAC_SH];
            rad3_reg  <= rad2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: depth times each tangent, floored to Q.8
    // ------------------------------------------------------------------
    logic signed [ZPROD_W-1:0] zpx_c, zpy_c;
    logic signed [ZZ_W-1:0]    zzx4_reg, zzy4_reg;
    logic signed [DEPTH_W-1:0] az4_reg;
    logic signed [AXC_W-1:0]   ax4_reg, ay4_reg;
    logic [DIST_W-1:0]         dist4_reg;
    logic [RAD_W-1:0]          rad4_reg;

    always_comb begin
        zpx_c = ZPROD_W'(az3_reg) * ZPROD_W'($signed({1'b0, tan_horiz_reg}));
        zpy_c = ZPROD_W'(az3_reg) * ZPROD_W'($signed({1'b0, tan_vert_reg}));
    end

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            zzx4_reg  <= $signed(zpx_c[ZPROD_W-2:FRAC_SH]);
            zzy4_reg  <= $signed(zpy_c[ZPROD_W-2:FRAC_SH]);
            az4_reg   <= az3_reg;
            ax4_reg   <= ax3_reg;
            ay4_reg   <= ay3_reg;
            dist4_reg <= dist3_reg;
            rad4_reg  <= rad3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: outer and inner bounds of every test
    // ------------------------------------------------------------------
    typedef struct packed {
        logic signed [CMP_W-1:0] hi_out;
        logic signed [CMP_W-1:0] lo_out;
        logic signed [CMP_W-1:0] hi_in;
        logic signed [CMP_W-1:0] lo_in;
    } bounds_t;

    bounds_t                 bx_next, by_next, bz_next, bx5_reg, by5_reg, bz5_reg;
    logic signed [CMP_W-1:0] dist_c, rad_c, near_c, far_c, zzx_c, zzy_c;
    logic signed [CMP_W-1:0] az5_reg, ax5_reg, ay5_reg;
    logic                    pt5_reg;

    always_comb begin
        dist_c = CMP_W'($signed({1'b0, dist4_reg}));
        rad_c  = CMP_W'($signed({1'b0, rad4_reg}));
        near_c = CMP_W'($signed({1'b0, near_far_reg[COORD_W-1:0]}));
        far_c  = CMP_W'($signed({1'b0, near_far_reg[NF_W-1:COORD_W]}));
        zzx_c  = CMP_W'(zzx4_reg);
        zzy_c  = CMP_W'(zzy4_reg);

        bx_next.hi_out = zzx_c + dist_c;
        bx_next.lo_out = -zzx_c - dist_c;
        bx_next.hi_in  = zzx_c - dist_c;
        bx_next.lo_in  = -zzx_c + dist_c;

        by_next.hi_out = zzy_c + dist_c;
        by_next.lo_out = -zzy_c - dist_c;
        by_next.hi_in  = zzy_c - dist_c;
        by_next.lo_in  = -zzy_c + dist_c;

        bz_next.hi_out = far_c + rad_c;
        bz_next.lo_out = near_c - rad_c;
        bz_next.hi_in  = far_c - rad_c;
        bz_next.lo_in  = near_c + rad_c;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            bx5_reg <= bx_next;
            by5_reg <= by_next;
            bz5_reg <= bz_next;
            az5_reg <= CMP_W'(az4_reg);
            ax5_reg <= CMP_W'(ax4_reg);
            ay5_reg <= CMP_W'(ay4_reg);
            pt5_reg <= (rad4_reg == '0);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: compare and hold the verdict for the output
    // ------------------------------------------------------------------
    verdict_t verdict_reg, verdict_next;
    logic     pt6_reg;
    logic     any_out, any_band;

    always_comb begin
        any_out  = (az5_reg > bz5_reg.hi_out) || (az5_reg < bz5_reg.lo_out)
                || (ax5_reg > bx5_reg.hi_out) || (ax5_reg < bx5_reg.lo_out)
                || (ay5_reg > by5_reg.hi_out) || (ay5_reg < by5_reg.lo_out);
        any_band = (az5_reg > bz5_reg.hi_in) || (az5_reg < bz5_reg.lo_in)
                || (ax5_reg > bx5_reg.hi_in) || (ax5_reg < bx5_reg.lo_in)
                || (ay5_reg > by5_reg.hi_in) || (ay5_reg < by5_reg.lo_in);
        if (any_out) begin
            verdict_next = VERDICT_OUTSIDE;
        end else if (any_band) begin
            verdict_next = VERDICT_INTERSECT;
        end else begin
            verdict_next = VERDICT_INSIDE;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[5]) begin
            verdict_reg <= verdict_next;
            pt6_reg     <= pt5_reg;
        end
    end

    assign m_valid   = vld_reg[NSTAGE-1];
    assign m_verdict = 2'(verdict_reg);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_RST(a_reset_empty, !aresetn |=> (vld_reg == '0), "pipeline not empty after reset")
    `ASSERT_CLK(a_enter, in_acc |=> vld_reg[0], "accepted sphere did not enter stage 1")
    `ASSERT_CLK(a_occupancy, $past(aresetn) |-> ($countones(vld_reg) + 32'($past(out_acc)) == $past($countones(vld_reg)) + 32'($past(in_acc))), "transaction lost or duplicated in pipeline")
    `ASSERT_CLK(a_point_verdict, (m_valid && pt6_reg) |-> (verdict_reg != VERDICT_INTERSECT), "point test gave intersect")

endmodule

`default_nettype wire
